### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the binomial coefficient block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define BC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`define BC_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define BC_ASSERT(label, clk, rst, prop)

`define BC_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

### hw/rtl/bc_pkg.sv
package bc_pkg;

  localparam int NW        = 6;
  localparam int COEF_W    = 31;
  localparam int STEP_W    = 5;
  localparam int PROD_W    = COEF_W + NW;
  localparam int REM_W     = 5;
  localparam int DIV_CNT_W = 6;
  localparam int DIV_STEPS = PROD_W;

  localparam logic [COEF_W-1:0] COEF_SAT = {COEF_W{1'b1}};

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_MUL   = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_step;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic last_step;
    logic div_last;
  } status_t;

endpackage

### hw/rtl/bc_ctrl.sv
`include "assert_macros.svh"

module bc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  bc_pkg::status_t status,
  output bc_pkg::cmd_t    cmd,
  output logic            busy,
  output logic            done
);
  import bc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.last_step) begin
          cmd.fin    = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_CHECK;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  `BC_ASSERT(a_done_single, clk, rst, done |=> !busy)
  `BC_ASSERT(a_load_to_check, clk, rst, cmd.load |=> (state == S_CHECK))
  `BC_ASSERT(a_div_exit, clk, rst, (cmd.div_step && status.div_last) |=> (state == S_CHECK))

endmodule

### hw/rtl/bc_dp.sv
`include "assert_macros.svh"

module bc_dp #(
  parameter int MAX_SET_SIZE = 33
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bc_pkg::cmd_t                cmd,
  input  logic [bc_pkg::NW-1:0]       set_size,
  input  logic [bc_pkg::NW-1:0]       choose_count,
  output bc_pkg::status_t             status,
  output logic [bc_pkg::COEF_W-1:0]   coefficient
);
  import bc_pkg::*;

  logic [NW-1:0]        n_r;
  logic [STEP_W-1:0]    steps;
  logic [STEP_W-1:0]    idx;
  logic                 k_above;
  logic                 n_big;
  logic [COEF_W-1:0]    acc;
  logic [PROD_W-1:0]    quo;
  logic [REM_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] dcnt;
  logic [COEF_W-1:0]    coef;

  logic [NW-1:0]        diff;
  logic [NW-1:0]        fold;
  logic                 k_above_in;
  logic                 n_big_in;
  logic [NW-1:0]        factor;
  logic [NW-1:0]        divisor;
  logic [NW-1:0]        r2;
  logic                 ge;
  logic [NW-1:0]        r2_sub;
  logic [PROD_W-1:0]    quo_next;

  assign k_above_in = (choose_count > set_size);
  assign n_big_in   = (set_size > NW'(MAX_SET_SIZE));
  assign diff       = set_size - choose_count;
  assign fold       = (choose_count > diff) ? diff : choose_count;

  assign factor   = n_r - {1'b0, idx};
  assign divisor  = {1'b0, idx} + NW'(1);
  assign r2       = {rem, quo[PROD_W-1]};
  assign ge       = (r2 >= divisor);
  assign r2_sub   = r2 - divisor;
  assign quo_next = {quo[PROD_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r     <= set_size;
      k_above <= k_above_in;
      n_big   <= n_big_in;
      idx     <= '0;
      acc     <= COEF_W'(1);
      if (k_above_in || n_big_in) begin
        steps <= '0;
      end else begin
        steps <= fold[STEP_W-1:0];
      end
    end
    if (cmd.mul) begin
      quo  <= PROD_W'(acc) * PROD_W'(factor);
      rem  <= '0;
      dcnt <= '0;
    end
    if (cmd.div_step) begin
      quo  <= quo_next;
      rem  <= ge ? r2_sub[REM_W-1:0] : r2[REM_W-1:0];
      dcnt <= dcnt + DIV_CNT_W'(1);
      if (status.div_last) begin
        acc <= quo_next[COEF_W-1:0];
        idx <= idx + STEP_W'(1);
      end
    end
    if (cmd.fin) begin
      if (k_above) begin
        coef <= '0;
      end else if (n_big) begin
        coef <= COEF_SAT;
      end else begin
        coef <= acc;
      end
    end
  end

  assign status.last_step = (idx == steps);
  assign status.div_last  = (dcnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign coefficient      = coef;

  `BC_ASSERT_NEVER(a_rem_below_divisor, clk, rst, cmd.div_step && ({1'b0, rem} >= divisor))

endmodule

### hw/rtl/binomial_coefficient.sv
// Each accepted start runs min(k, n - k) steps, each a multiply and a restoring divide;
// no steps run when k > n or n exceeds MAX_SET_SIZE.
// Throughput: one item at a time; busy stays high until the done cycle has passed.
// The receiver cannot stall: coefficient is valid for the single cycle done is high.
// Reset (rst, synchronous, active high) returns the controller to idle.
module binomial_coefficient #(
  parameter int MAX_SET_SIZE = 33
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [bc_pkg::NW-1:0]     set_size,
  input  logic [bc_pkg::NW-1:0]     choose_count,
  output logic                      done,
  output logic [bc_pkg::COEF_W-1:0] coefficient
);
  import bc_pkg::*;

  cmd_t    cmd;
  status_t status;

  bc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  bc_dp #(
    .MAX_SET_SIZE (MAX_SET_SIZE)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .set_size     (set_size),
    .choose_count (choose_count),
    .status       (status),
    .coefficient  (coefficient)
  );

endmodule

### verif/binomial_coefficient_tb.sv
module binomial_coefficient_tb;

  import bc_pkg::*;

  localparam int MAX_N       = 33;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN       = 700;

  class coef_board;
    logic [COEF_W-1:0] want_q[$];
    logic [NW-1:0]     n_q[$];
    logic [NW-1:0]     k_q[$];
    int errors;
    int seen;
    int n_zero;
    int n_sat;
    int n_exact;

    function new();
      errors = 0;
      seen = 0;
      n_zero = 0;
      n_sat = 0;
      n_exact = 0;
    endfunction

    function automatic logic [COEF_W-1:0] choose(logic [NW-1:0] n, logic [NW-1:0] k);
      logic [63:0] acc;
      int steps;
      if (k > n) return '0;
      if (n > MAX_N) return COEF_SAT;
      steps = (k > n - k) ? int'(n - k) : int'(k);
      acc = 64'd1;
      for (int i = 0; i < steps; i++) begin
        acc = acc * (64'(n) - 64'(i));
        acc = acc / (64'(i) + 64'd1);
      end
      if (acc > 64'(COEF_SAT)) return COEF_SAT;
      return acc[COEF_W-1:0];
    endfunction

    function void note(logic [NW-1:0] n, logic [NW-1:0] k);
      logic [COEF_W-1:0] c;
      c = choose(n, k);
      if (c == '0) n_zero++;
      else if (c == COEF_SAT) n_sat++;
      else n_exact++;
      want_q = {want_q, c};
      n_q = {n_q, n};
      k_q = {k_q, k};
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task check(logic [COEF_W-1:0] got);
      logic [COEF_W-1:0] want;
      logic [NW-1:0] n;
      logic [NW-1:0] k;
      seen++;
      if (want_q.size() == 0) begin
        report($sformatf("result %0d arrived with no beat outstanding", got));
      end else begin
        want = want_q.pop_front();
        n = n_q.pop_front();
        k = k_q.pop_front();
        if (got !== want)
          report($sformatf("C(%0d,%0d): coefficient %0d, expected %0d", n, k, got, want));
      end
    endtask

    function int pending();
      return want_q.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [NW-1:0]     set_size = '0;
  logic [NW-1:0]     choose_count = '0;
  logic              done;
  logic [COEF_W-1:0] coefficient;

  coef_board board = new();
  int items = 0;
  int cycles = 0;

  binomial_coefficient #(.MAX_SET_SIZE(MAX_N)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .set_size(set_size),
    .choose_count(choose_count),
    .done(done),
    .coefficient(coefficient)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycles,
               board.pending());
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) board.note(set_size, choose_count);
      if (done) board.check(coefficient);
    end
  end

  task automatic send_beat(input logic [NW-1:0] n, input logic [NW-1:0] k);
    set_size <= n;
    choose_count <= k;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    items++;
  endtask

  task automatic idle(input int count);
    if (count > 0) begin
      start <= 1'b0;
      repeat (count) @(posedge clk);
    end
  endtask

  task automatic wait_results();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending() > 0) @(posedge clk);
  endtask

  task automatic send_random();
    int n;
    int k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: begin
        n = $urandom_range(0, MAX_N);
        k = $urandom_range(0, n);
      end
      7: begin
        n = $urandom_range(MAX_N + 1, 63);
        k = $urandom_range(0, n);
      end
      8: begin
        n = $urandom_range(0, 62);
        k = $urandom_range(n + 1, 63);
      end
      default: begin
        n = $urandom_range(0, 63);
        k = $urandom_range(0, 63);
      end
    endcase
    send_beat(NW'(n), NW'(k));
  endtask

  initial begin
    int burst;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_beat(6'd0, 6'd0);
    send_beat(6'd0, 6'd1);
    send_beat(6'd0, 6'd63);
    send_beat(6'd1, 6'd0);
    send_beat(6'd1, 6'd1);
    send_beat(6'd5, 6'd2);
    idle(3);
    send_beat(6'd10, 6'd3);
    send_beat(6'd16, 6'd8);
    send_beat(6'd20, 6'd10);
    send_beat(6'd31, 6'd15);
    send_beat(6'd32, 6'd16);
    send_beat(6'd33, 6'd0);
    send_beat(6'd33, 6'd1);
    idle(1);
    send_beat(6'd33, 6'd16);
    send_beat(6'd33, 6'd17);
    send_beat(6'd33, 6'd32);
    send_beat(6'd33, 6'd33);
    send_beat(6'd33, 6'd34);
    send_beat(6'd34, 6'd17);
    send_beat(6'd34, 6'd35);
    send_beat(6'd63, 6'd0);
    send_beat(6'd63, 6'd62);
    send_beat(6'd63, 6'd63);
    send_beat(6'd62, 6'd63);
    wait_results();

    for (int i = 0; i < 400; i += burst) begin
      burst = $urandom_range(1, 12);
      for (int j = 0; j < burst; j++) send_random();
      if (i < 200 && i + burst >= 200) wait_results();
      else if ($urandom_range(0, 3) == 0) idle(0);
      else idle($urandom_range(1, 20));
    end

    wait_results();
    repeat (DRAIN) @(posedge clk);

    $display("Sent %0d beats, checked %0d results in %0d cycles", items, board.seen, cycles);
    $display("Expected values: %0d exact, %0d zero, %0d saturated", board.n_exact,
             board.n_zero, board.n_sat);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
